@@ hw/rtl/vtsc_pkg.sv @@
// Shared types and codes for the tour split cost unit.
// Holds the item structs, the sequencer-to-datapath tag and the memory control group.
// No dependencies.
package vtsc_pkg;

  localparam int NODE_W    = 6;
  localparam int VAL_W     = 24;
  localparam int COST_W    = 32;
  localparam int DEM_W     = 16;
  localparam int TIME_W    = 24;
  localparam int CFG_IDX_W = 2;

  // Item kinds
  localparam logic [1:0] KIND_DIST = 2'd0;
  localparam logic [1:0] KIND_DEM  = 2'd1;
  localparam logic [1:0] KIND_CUST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VCAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TMAX = 2'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [VAL_W-1:0]  value;
    logic              last;
  } vtsc_in_t;

  typedef struct packed {
    logic [COST_W-1:0] total_cost;
    logic              overflow;
  } vtsc_out_t;

  // Describes what the distance and demand read registers hold this cycle
  typedef struct packed {
    logic ph0;     // reads of phase 0: d(prev,cust), d(cust,0), demand
    logic ph1;     // reads of phase 1: d(prev,0), d(0,cust)
    logic ok_x;    // port x address in range
    logic ok_y;    // port y address in range
    logic ok_dem;  // demand address in range
    logic first;   // customer opens a tour
    logic last;    // customer closes the tour
  } vtsc_tag_t;

  typedef struct packed {
    logic x_en;
    logic x_we;
    logic y_en;
    logic dem_en;
    logic dem_we;
  } vtsc_mem_ctl_t;

endpackage

@@ hw/rtl/vtsc_dist_ram.sv @@
// Distance table: one read/write port and one read port, registered read data.
// Depends on nothing but its parameters.
module vtsc_dist_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 24
) (
  input  logic          clk_i,
  input  logic          x_en_i,
  input  logic          x_we_i,
  input  logic [AW-1:0] x_addr_i,
  input  logic [DW-1:0] x_wdata_i,
  output logic [DW-1:0] x_rdata_o,
  input  logic          y_en_i,
  input  logic [AW-1:0] y_addr_i,
  output logic [DW-1:0] y_rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (x_en_i) begin
      if (x_we_i) begin
        mem[x_addr_i] <= x_wdata_i;
      end else begin
        x_rdata_o <= mem[x_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_en_i) begin
      y_rdata_o <= mem[y_addr_i];
    end
  end

endmodule

@@ hw/rtl/vtsc_dem_ram.sv @@
// Demand table: single read/write port with registered read data.
// Uses vtsc_pkg for the demand width.
module vtsc_dem_ram
  import vtsc_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [DEM_W-1:0] wdata_i,
  output logic [DEM_W-1:0] rdata_o
);

  logic [DEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

@@ hw/rtl/vtsc_issue.sv @@
// Input stage and memory sequencer: writes the tables, issues the two read phases of a customer.
// Tracks the previous node and tour start. Uses vtsc_pkg.
module vtsc_issue
  import vtsc_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int DIST_BITS  = 24,
  parameter int AW         = 12,
  parameter int NW         = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  vtsc_in_t             in_item_i,
  output logic                 in_stall_o,
  input  logic                 adv_i,
  output vtsc_mem_ctl_t        mem_ctl_o,
  output logic [AW-1:0]        x_addr_o,
  output logic [AW-1:0]        y_addr_o,
  output logic [DIST_BITS-1:0] x_wdata_o,
  output logic [NW-1:0]        dem_addr_o,
  output logic [DEM_W-1:0]     dem_wdata_o,
  output vtsc_tag_t            tag_o
);

  function automatic logic [AW-1:0] cell_addr(input logic [NODE_W-1:0] r,
                                              input logic [NODE_W-1:0] c);
    return AW'(r) * AW'(NODE_COUNT) + AW'(c);
  endfunction

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    return 32'(n) < 32'(NODE_COUNT);
  endfunction

  logic              iss_v_q, iss_v_d;
  vtsc_in_t          iss_q;
  logic              ph_q, ph_d;
  logic [NODE_W-1:0] prev_q;
  logic              started_q;
  vtsc_tag_t         tag_q, tag_d;
  logic              is_cust, is_dist, is_dem;
  logic              a_ok, b_ok, p_ok, accept;

  assign is_cust = iss_v_q && (iss_q.kind == KIND_CUST);
  assign is_dist = iss_v_q && (iss_q.kind == KIND_DIST);
  assign is_dem  = iss_v_q && (iss_q.kind == KIND_DEM);
  assign a_ok    = node_ok(iss_q.node_a);
  assign b_ok    = node_ok(iss_q.node_b);
  assign p_ok    = node_ok(prev_q);

  // A customer holds the stage for its two read phases
  assign in_stall_o = !adv_i || (is_cust && !ph_q);
  assign accept     = in_valid_i && !in_stall_o;
  assign iss_v_d    = accept || (is_cust && !ph_q);
  assign ph_d       = is_cust && !ph_q;

  always_comb begin
    mem_ctl_o.x_we   = is_dist && a_ok && b_ok;
    mem_ctl_o.x_en   = adv_i && (is_cust || mem_ctl_o.x_we);
    mem_ctl_o.y_en   = adv_i && is_cust;
    mem_ctl_o.dem_we = is_dem && a_ok;
    mem_ctl_o.dem_en = adv_i && ((is_cust && !ph_q) || mem_ctl_o.dem_we);
  end

  always_comb begin
    if (is_cust) begin
      x_addr_o = ph_q ? cell_addr(prev_q, '0) : cell_addr(prev_q, iss_q.node_a);
    end else begin
      x_addr_o = cell_addr(iss_q.node_a, iss_q.node_b);
    end
    y_addr_o = ph_q ? cell_addr('0, iss_q.node_a) : cell_addr(iss_q.node_a, '0);
  end

  assign x_wdata_o   = DIST_BITS'(iss_q.value);
  assign dem_addr_o  = NW'(iss_q.node_a);
  assign dem_wdata_o = iss_q.value[DEM_W-1:0];

  always_comb begin
    tag_d.ph0    = is_cust && !ph_q;
    tag_d.ph1    = is_cust && ph_q;
    tag_d.ok_x   = ph_q ? p_ok : (p_ok && a_ok);
    tag_d.ok_y   = a_ok;
    tag_d.ok_dem = a_ok;
    tag_d.first  = !started_q;
    tag_d.last   = iss_q.last;
  end

  assign tag_o = tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_v_q   <= 1'b0;
      ph_q      <= 1'b0;
      prev_q    <= '0;
      started_q <= 1'b0;
      tag_q     <= '0;
    end else if (adv_i) begin
      iss_v_q <= iss_v_d;
      ph_q    <= ph_d;
      tag_q   <= tag_d;
      if (is_cust && ph_q) begin
        started_q <= !iss_q.last;
        prev_q    <= iss_q.last ? '0 : iss_q.node_a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      iss_q <= in_item_i;
    end
  end

  a_phase_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_q.ph0 && adv_i) |=> tag_q.ph1)
    else $error("phase 0 reads not followed by phase 1 reads");

  a_cust_interlock : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_cust && !ph_q) |-> in_stall_o)
    else $error("new transaction accepted during phase 0 of a customer");

  a_tour_start_depot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> (prev_q == '0))
    else $error("previous node not at depot outside a tour");

endmodule

@@ hw/rtl/vtsc_split.sv @@
// Split datapath: evaluates the closing rule and updates route, capacity and cost.
// Two stages (decide, update) and the result register. Uses vtsc_pkg.
module vtsc_split
  import vtsc_pkg::*;
#(
  parameter int DIST_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 adv_o,
  input  vtsc_tag_t            tag_i,
  input  logic [DIST_BITS-1:0] x_rdata_i,
  input  logic [DIST_BITS-1:0] y_rdata_i,
  input  logic [DEM_W-1:0]     dem_rdata_i,
  input  logic [DEM_W-1:0]     vcap_i,
  input  logic [TIME_W-1:0]    tmax_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vtsc_out_t            out_item_o
);

  localparam int SUM_W = COST_W + 3;
  localparam logic [SUM_W-1:0] SAT = SUM_W'({COST_W{1'b1}});

  // Phase 0 data, held until phase 1 data arrives
  logic [DIST_BITS-1:0] hold_pc_q, hold_c0_q;
  logic [DIST_BITS:0]   hold_pcc0_q;
  logic [DEM_W-1:0]     hold_dem_q;

  // Decide stage
  logic                 e1_v_q, e1_close_q, e1_last_q, e1_first_q;
  logic [SUM_W-1:0]     e1_x_q, e1_y_q, e1_e_q;
  logic [DIST_BITS:0]   e1_z_q;
  logic [DIST_BITS-1:0] e1_d0c_q;
  logic [DEM_W-1:0]     e1_dem_q, e1_cap_q;

  // Tour state
  logic [COST_W-1:0]    route_q, route_d, cost_q, cost_d;
  logic [DEM_W-1:0]     cap_q, cap_d;
  logic                 ovf_q, ovf_d;

  logic                 out_valid_q;
  vtsc_out_t            out_q;

  logic [DIST_BITS-1:0] x_dat, y_dat;
  logic [DEM_W-1:0]     dem_dat;
  logic [COST_W-1:0]    rl;
  logic [DEM_W-1:0]     cap;
  logic [SUM_W-1:0]     y_sum, x_sum, e_sum, det_sum;
  logic                 too_long, too_heavy, detour;

  logic                 e2_fire;
  logic [COST_W-1:0]    cost_eff;
  logic                 ovf_eff;
  logic [SUM_W-1:0]     add1, add2, total;
  logic                 cost_ovf, rl_ovf, big_dem;

  assign x_dat   = tag_i.ok_x ? x_rdata_i : '0;
  assign y_dat   = tag_i.ok_y ? y_rdata_i : '0;
  assign dem_dat = tag_i.ok_dem ? dem_rdata_i : '0;

  // Freeze everything while a finished tour waits on a stalled result register
  assign adv_o   = !(e1_v_q && e1_last_q && out_valid_q && out_stall_i);
  assign e2_fire = adv_o && e1_v_q;

  always_ff @(posedge clk_i) begin
    if (adv_o && tag_i.ph0) begin
      hold_pc_q   <= x_dat;
      hold_c0_q   <= y_dat;
      hold_pcc0_q <= (DIST_BITS+1)'(x_dat) + (DIST_BITS+1)'(y_dat);
      hold_dem_q  <= dem_dat;
    end
  end

  // Decide: x_dat is d(prev,0), y_dat is d(0,cust) in phase 1
  always_comb begin
    rl        = tag_i.first ? '0 : route_q;
    cap       = tag_i.first ? vcap_i : cap_q;
    y_sum     = SUM_W'(rl) + SUM_W'(hold_pcc0_q);
    x_sum     = SUM_W'(rl) + SUM_W'(x_dat);
    e_sum     = SUM_W'(rl) + SUM_W'(hold_pc_q);
    det_sum   = SUM_W'(x_dat) + SUM_W'(y_dat);
    too_long  = y_sum > SUM_W'(tmax_i);
    too_heavy = hold_dem_q > cap;
    detour    = det_sum < SUM_W'(hold_pc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
    end else if (adv_o) begin
      e1_v_q <= tag_i.ph1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && tag_i.ph1) begin
      e1_close_q <= too_long || too_heavy || detour;
      e1_last_q  <= tag_i.last;
      e1_first_q <= tag_i.first;
      e1_x_q     <= x_sum;
      e1_y_q     <= y_sum;
      e1_e_q     <= e_sum;
      e1_z_q     <= (DIST_BITS+1)'(y_dat) + (DIST_BITS+1)'(hold_c0_q);
      e1_d0c_q   <= y_dat;
      e1_dem_q   <= hold_dem_q;
      e1_cap_q   <= cap;
    end
  end

  // Update: chained saturating adds of non-negative terms collapse to one
  // sum that saturates once and flags when the exact total exceeds the limit
  always_comb begin
    cost_eff = e1_first_q ? '0 : cost_q;
    ovf_eff  = e1_first_q ? 1'b0 : ovf_q;
    if (e1_close_q) begin
      add1 = e1_x_q;
      add2 = e1_last_q ? SUM_W'(e1_z_q) : '0;
    end else begin
      add1 = e1_last_q ? e1_y_q : '0;
      add2 = '0;
    end
    total    = SUM_W'(cost_eff) + add1 + add2;
    cost_ovf = total > SAT;
    cost_d   = cost_ovf ? '1 : total[COST_W-1:0];
    rl_ovf   = e1_e_q > SAT;
    big_dem  = e1_dem_q > vcap_i;
    if (e1_close_q) begin
      route_d = COST_W'(e1_d0c_q);
      cap_d   = big_dem ? '0 : vcap_i - e1_dem_q;
      ovf_d   = ovf_eff || cost_ovf || big_dem;
    end else begin
      route_d = rl_ovf ? '1 : e1_e_q[COST_W-1:0];
      cap_d   = e1_cap_q - e1_dem_q;
      ovf_d   = ovf_eff || cost_ovf || rl_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_q <= '0;
      cap_q   <= '0;
      cost_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (e2_fire) begin
      route_q <= route_d;
      cap_q   <= cap_d;
      cost_q  <= cost_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (e2_fire && e1_last_q) || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (e2_fire && e1_last_q) begin
      out_q.total_cost <= cost_d;
      out_q.overflow   <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_no_stage_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_i.ph1 |-> !e1_v_q)
    else $error("customer decided before previous state update completed");

  a_capacity_no_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e1_v_q && !e1_close_q) |-> (e1_dem_q <= e1_cap_q))
    else $error("route extended past remaining capacity");

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e2_fire && e1_last_q) |=> out_valid_o)
    else $error("closed tour produced no result");

endmodule

@@ hw/rtl/vrp_tour_split_cost_unit.sv @@
// Tour split cost unit: greedy split of a giant tour into depot routes with a running cost.
// Usage:
//   The in channel (in_valid_i / in_stall_o) carries one transaction per item: distance
//   writes, demand writes and tour customers. A customer's four distance reads go through
//   the two ports of the distance memory in two phases, and in_stall_o holds off the next
//   item until its second phase is issued.
//   A customer marked last produces one result on the out channel (out_valid_o /
//   out_stall_i): total cost and the overflow flag.
//   The config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0 sets the
//   vehicle capacity, index 1 the route time limit, other indexes are dropped.
//   Write configuration only while no transaction is in flight.
//   Reset clears the pipeline, the tour state and the registers (capacity and time limit
//   go to all ones); table contents are undefined until written, with no clearing pass.
//   A stalled result is held in the output register while the block keeps accepting;
//   only when a second tour result is ready does the pipeline freeze and raise in_stall_o.
// Depends on vtsc_pkg, vtsc_issue, vtsc_split, vtsc_dist_ram, vtsc_dem_ram.
module vrp_tour_split_cost_unit
  import vtsc_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int DIST_BITS  = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  vtsc_in_t             in_item_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vtsc_out_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TIME_W-1:0]    cfg_data_i
);

  localparam int DEPTH = NODE_COUNT * NODE_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(NODE_COUNT);

  logic [DEM_W-1:0]     vcap_q;
  logic [TIME_W-1:0]    tmax_q;

  logic                 adv;
  vtsc_mem_ctl_t        mem_ctl;
  vtsc_tag_t            tag;
  logic [AW-1:0]        x_addr, y_addr;
  logic [DIST_BITS-1:0] x_wdata, x_rdata, y_rdata;
  logic [NW-1:0]        dem_addr;
  logic [DEM_W-1:0]     dem_wdata, dem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcap_q <= '1;
      tmax_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_VCAP: vcap_q <= cfg_data_i[DEM_W-1:0];
        CFG_TMAX: tmax_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  vtsc_issue #(
    .NODE_COUNT(NODE_COUNT),
    .DIST_BITS (DIST_BITS),
    .AW        (AW),
    .NW        (NW)
  ) u_issue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .adv_i      (adv),
    .mem_ctl_o  (mem_ctl),
    .x_addr_o   (x_addr),
    .y_addr_o   (y_addr),
    .x_wdata_o  (x_wdata),
    .dem_addr_o (dem_addr),
    .dem_wdata_o(dem_wdata),
    .tag_o      (tag)
  );

  vtsc_dist_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (DIST_BITS)
  ) u_dist_ram (
    .clk_i    (clk_i),
    .x_en_i   (mem_ctl.x_en),
    .x_we_i   (mem_ctl.x_we),
    .x_addr_i (x_addr),
    .x_wdata_i(x_wdata),
    .x_rdata_o(x_rdata),
    .y_en_i   (mem_ctl.y_en),
    .y_addr_i (y_addr),
    .y_rdata_o(y_rdata)
  );

  vtsc_dem_ram #(
    .DEPTH(NODE_COUNT),
    .AW   (NW)
  ) u_dem_ram (
    .clk_i  (clk_i),
    .en_i   (mem_ctl.dem_en),
    .we_i   (mem_ctl.dem_we),
    .addr_i (dem_addr),
    .wdata_i(dem_wdata),
    .rdata_o(dem_rdata)
  );

  vtsc_split #(
    .DIST_BITS(DIST_BITS)
  ) u_split (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_o      (adv),
    .tag_i      (tag),
    .x_rdata_i  (x_rdata),
    .y_rdata_i  (y_rdata),
    .dem_rdata_i(dem_rdata),
    .vcap_i     (vcap_q),
    .tmax_i     (tmax_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
